/* src/tbc_pkg.sv */
// Package for the toy byte block cipher: widths, action codes, S-boxes,
// nibble permutations and the round functions shared by the datapath files.
// No dependencies.
`timescale 1ns / 1ps

package tbc_pkg;

	localparam int NIB_W    = 4;
	localparam int BLK_W    = 8;
	localparam int KEY_W    = 8;
	localparam int ROUNDS   = 4;
	localparam int RC_MULT  = 3;

	typedef logic [NIB_W-1:0] nib_t;
	typedef logic [BLK_W-1:0] blk_t;
	typedef logic [KEY_W-1:0] key_t;

	typedef enum logic {
		ACT_ENCRYPT = 1'b0,
		ACT_DECRYPT = 1'b1
	} action_t;

	// Element i gives the source position (from the MSB) of output bit i.
	typedef logic [0:3][1:0] perm_t;

	// Round keys, index = round number.
	typedef nib_t [ROUNDS-1:0] rkeys_t;

	localparam nib_t FWD_SBOX [16] = '{
		4'h9, 4'h4, 4'h0, 4'hD, 4'h8, 4'h5, 4'h1, 4'hC,
		4'hB, 4'h6, 4'h2, 4'hF, 4'hA, 4'h7, 4'h3, 4'hE
	};
	localparam nib_t INV_SBOX [16] = '{
		4'h2, 4'h6, 4'hA, 4'hE, 4'h1, 4'h5, 4'h9, 4'hD,
		4'h4, 4'h0, 4'hC, 4'h8, 4'h7, 4'h3, 4'hF, 4'hB
	};

	localparam perm_t PERM_A     = {2'd2, 2'd0, 2'd3, 2'd1};
	localparam perm_t PERM_A_INV = {2'd1, 2'd3, 2'd0, 2'd2};
	localparam perm_t PERM_B     = {2'd3, 2'd2, 2'd0, 2'd1};
	localparam perm_t PERM_B_INV = {2'd2, 2'd3, 2'd1, 2'd0};

	function automatic nib_t nib_permute(input perm_t map, input nib_t x);
		nib_t y;
		y = '0;
		for (int i = 0; i < NIB_W; i++) begin
			y[2'(3 - i)] = x[~map[i]];
		end
		return y;
	endfunction

	function automatic nib_t round_key(input key_t key, input int r);
		nib_t rot;
		rot = {key[2:0], 1'b0} | key[6:3];
		return rot ^ NIB_W'(RC_MULT * r);
	endfunction

	function automatic blk_t fwd_round(input blk_t blk, input nib_t k);
		nib_t left;
		nib_t right;
		nib_t t;
		left  = blk[7:4];
		right = blk[3:0];
		t = nib_permute(PERM_A, left ^ right);
		t = FWD_SBOX[t] ^ k;
		t = nib_permute(PERM_B, t);
		return {left ^ t, left};
	endfunction

	function automatic blk_t inv_round(input blk_t blk, input nib_t k);
		nib_t left;
		nib_t right;
		nib_t t;
		left  = blk[7:4];
		right = blk[3:0];
		t = nib_permute(PERM_B_INV, left ^ right);
		t = INV_SBOX[t ^ k];
		t = nib_permute(PERM_A_INV, t);
		return {right, right ^ t};
	endfunction

endpackage

/* src/tbc_key_sched.sv */
// Round key schedule: derives the four round keys from the key byte.
// Depends on tbc_pkg.
`timescale 1ns / 1ps

module tbc_key_sched (
	input  tbc_pkg::key_t   key,
	output tbc_pkg::rkeys_t rkeys
);

	always_comb begin
		for (int r = 0; r < tbc_pkg::ROUNDS; r++) begin
			rkeys[r] = tbc_pkg::round_key(key, r);
		end
	end

endmodule

/* src/tbc_rounds.sv */
// Four cipher rounds in both directions, selected by the action bit.
// Depends on tbc_pkg.
`timescale 1ns / 1ps

module tbc_rounds (
	input  tbc_pkg::action_t action,
	input  tbc_pkg::blk_t    blk_in,
	input  tbc_pkg::rkeys_t  rkeys,
	output tbc_pkg::blk_t    blk_out
);

	tbc_pkg::blk_t enc;
	tbc_pkg::blk_t dec;

	always_comb begin
		enc = blk_in;
		dec = blk_in;
		for (int r = 0; r < tbc_pkg::ROUNDS; r++) begin
			enc = tbc_pkg::fwd_round(enc, rkeys[r]);
			dec = tbc_pkg::inv_round(dec, rkeys[tbc_pkg::ROUNDS - 1 - r]);
		end
		unique case (action)
			tbc_pkg::ACT_ENCRYPT: blk_out = enc;
			tbc_pkg::ACT_DECRYPT: blk_out = dec;
			default:              blk_out = enc;
		endcase
	end

endmodule

/* src/toy_byte_block_cipher.sv */
// Toy byte block cipher top level: key register, input and result stages.
// Depends on tbc_pkg, tbc_key_sched and tbc_rounds.
//
// Usage:
// - Write the key byte through cfg_wr_en / cfg_wr_data while the block is
//   idle; it takes effect at once, with no handshake and no read-back.
// - Input beats (action, data_block) enter on in_valid / in_ready; each
//   gives exactly one output beat (result_block) on out_valid / out_ready.
// - An accepted beat waits in the input stage, passes all four rounds and is
//   presented from the result register. Throughput: one beat per cycle while
//   out_ready is high, set by the input stage and the result register.
// - When the receiver stalls, the result register holds; the input stage
//   keeps one more beat, then in_ready drops until out_ready returns.
// - Reset clears both stages and sets the key to zero.
`timescale 1ns / 1ps

module toy_byte_block_cipher (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  tbc_pkg::key_t        cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 action,
	input  tbc_pkg::blk_t        data_block,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tbc_pkg::blk_t        result_block
);

	tbc_pkg::key_t    key_q;
	logic             vld_s1;
	tbc_pkg::action_t act_s1;
	tbc_pkg::blk_t    blk_s1;
	logic             vld_s2;
	tbc_pkg::blk_t    blk_s2;
	tbc_pkg::rkeys_t  rkeys;
	tbc_pkg::blk_t    rnd_out;
	logic             adv_s1;

	assign adv_s1   = !vld_s2 || out_ready;
	assign in_ready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_wr_en) begin
			key_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			act_s1 <= tbc_pkg::action_t'(action);
			blk_s1 <= data_block;
		end
	end

	tbc_key_sched u_key_sched (
		.key   (key_q),
		.rkeys (rkeys)
	);

	tbc_rounds u_rounds (
		.action  (act_s1),
		.blk_in  (blk_s1),
		.rkeys   (rkeys),
		.blk_out (rnd_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && vld_s1) begin
			blk_s2 <= rnd_out;
		end
	end

	assign out_valid    = vld_s2;
	assign result_block = blk_s2;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s1)
		else $error("accepted beat did not reach the input stage");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv_s1 |=> vld_s1 && $stable(blk_s1) && $stable(act_s1))
		else $error("input stage lost its beat during a stall");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv_s1 |=> out_valid)
		else $error("input stage advanced without filling the result register");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> in_ready)
		else $error("empty input stage refused a beat");

endmodule

/* tb/tbc_scoreboard.sv */
// Checker for the toy byte block cipher: tracks the key register, predicts
// each result beat from its input beat and compares in order.
// Depends on tbc_pkg for types and the action codes.
`timescale 1ns / 1ps

module tbc_scoreboard (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  tbc_pkg::key_t cfg_wr_data,
	input  logic          in_valid,
	input  logic          in_ready,
	input  logic          action,
	input  tbc_pkg::blk_t data_block,
	input  logic          out_valid,
	input  logic          out_ready,
	input  tbc_pkg::blk_t result_block,
	output int            results_due,
	output int            errors
);

	typedef struct packed {
		tbc_pkg::action_t act;
		tbc_pkg::blk_t    src;
		tbc_pkg::blk_t    result;
	} cipher_beat_t;

	localparam tbc_pkg::nib_t SBOX_FWD [16] = '{
		4'h9, 4'h4, 4'h0, 4'hD, 4'h8, 4'h5, 4'h1, 4'hC,
		4'hB, 4'h6, 4'h2, 4'hF, 4'hA, 4'h7, 4'h3, 4'hE
	};
	localparam tbc_pkg::nib_t SBOX_INV [16] = '{
		4'h2, 4'h6, 4'hA, 4'hE, 4'h1, 4'h5, 4'h9, 4'hD,
		4'h4, 4'h0, 4'hC, 4'h8, 4'h7, 4'h3, 4'hF, 4'hB
	};

	localparam tbc_pkg::perm_t SHUF_A     = {2'd2, 2'd0, 2'd3, 2'd1};
	localparam tbc_pkg::perm_t SHUF_A_INV = {2'd1, 2'd3, 2'd0, 2'd2};
	localparam tbc_pkg::perm_t SHUF_B     = {2'd3, 2'd2, 2'd0, 2'd1};
	localparam tbc_pkg::perm_t SHUF_B_INV = {2'd2, 2'd3, 2'd1, 2'd0};

	tbc_pkg::key_t key_copy;
	cipher_beat_t  head;
	cipher_beat_t  pending_results [$];

	// Output bit i, counted from the MSB, takes input bit map[i], counted likewise.
	function automatic tbc_pkg::nib_t shuffle_nib(input tbc_pkg::perm_t map,
		input tbc_pkg::nib_t x);
		tbc_pkg::nib_t y;
		y = '0;
		for (int i = 0; i < 4; i++) begin
			y[3 - i] = x[3 - int'(map[i])];
		end
		return y;
	endfunction

	function automatic tbc_pkg::nib_t subkey(input tbc_pkg::key_t key, input int rnd);
		tbc_pkg::nib_t rot;
		rot = {key[2:0], 1'b0} | key[6:3];
		return rot ^ tbc_pkg::nib_t'(3 * rnd);
	endfunction

	function automatic tbc_pkg::blk_t cipher_byte(input tbc_pkg::action_t act,
		input tbc_pkg::blk_t blk, input tbc_pkg::key_t key);
		tbc_pkg::blk_t b;
		tbc_pkg::nib_t l;
		tbc_pkg::nib_t r;
		tbc_pkg::nib_t t;
		b = blk;
		if (act == tbc_pkg::ACT_ENCRYPT) begin
			for (int rnd = 0; rnd < 4; rnd++) begin
				l = b[7:4];
				r = b[3:0];
				t = shuffle_nib(SHUF_A, l ^ r);
				t = SBOX_FWD[t] ^ subkey(key, rnd);
				t = shuffle_nib(SHUF_B, t);
				b = {l ^ t, l};
			end
		end else begin
			for (int rnd = 3; rnd >= 0; rnd--) begin
				l = b[7:4];
				r = b[3:0];
				t = shuffle_nib(SHUF_B_INV, l ^ r);
				t = SBOX_INV[t ^ subkey(key, rnd)];
				t = shuffle_nib(SHUF_A_INV, t);
				b = {r, r ^ t};
			end
		end
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_copy = '0;
			pending_results.delete();
			results_due = 0;
			errors = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result beat with nothing expected, expected none, got %02h",
						$time, result_block);
				end else begin
					head = pending_results.pop_front();
					if (head.result !== result_block) begin
						errors++;
						$display("%0t: result_block mismatch (%s %02h), expected %02h, got %02h",
							$time, head.act.name(), head.src, head.result, result_block);
					end
				end
			end
			if (in_valid && in_ready) begin
				pending_results.push_back('{act: tbc_pkg::action_t'(action), src: data_block,
					result: cipher_byte(tbc_pkg::action_t'(action), data_block, key_copy)});
			end
			if (cfg_wr_en) begin
				key_copy = cfg_wr_data;
			end
			results_due = pending_results.size();
		end
	end

endmodule

/* tb/toy_byte_block_cipher_test.sv */
// Top of the toy byte block cipher testbench: clock, reset, key writes,
// input and result traffic under several idle patterns, and the verdict.
// Depends on tbc_pkg, toy_byte_block_cipher and tbc_scoreboard.
`timescale 1ns / 1ps

module toy_byte_block_cipher_test;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          cfg_wr_en;
	tbc_pkg::key_t cfg_wr_data;
	logic          in_valid;
	logic          in_ready;
	logic          action;
	tbc_pkg::blk_t data_block;
	logic          out_valid;
	logic          out_ready;
	tbc_pkg::blk_t result_block;

	int results_due;
	int errors;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	toy_byte_block_cipher i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.data_block   (data_block),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_block (result_block)
	);

	tbc_scoreboard i_scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.data_block   (data_block),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_block (result_block),
		.results_due  (results_due),
		.errors       (errors)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_block(input tbc_pkg::action_t act, input tbc_pkg::blk_t blk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		data_block = blk;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Hold off until every result beat is back, then let the pipeline empty.
	task automatic settle();
		in_valid = 1'b0;
		while (results_due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_key(input tbc_pkg::key_t k);
		settle();
		cfg_wr_en = 1'b1;
		cfg_wr_data = k;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	initial begin
		tbc_pkg::blk_t corner_blocks [11];
		tbc_pkg::key_t phase_keys [6];
		tbc_pkg::key_t k;

		corner_blocks = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h01,
			8'h55, 8'hAA, 8'h7E, 8'h81, 8'h3C};
		phase_keys = '{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hA5};
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		action = 1'b0;
		data_block = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (corner_blocks[i]) begin
			send_block(tbc_pkg::ACT_ENCRYPT, corner_blocks[i]);
			send_block(tbc_pkg::ACT_DECRYPT, corner_blocks[i]);
		end

		for (int ph = 0; ph < 8; ph++) begin
			k = (ph < 6) ? phase_keys[ph] : tbc_pkg::key_t'($urandom_range(255));
			load_key(k);
			unique case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 67;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 67;
				end
				default: begin
					send_idle_pct = 33;
					recv_stall_pct = 33;
				end
			endcase
			for (int n = 0; n < 125; n++) begin
				if (n == 60 && ph == 5) begin
					settle();
				end
				send_block(tbc_pkg::action_t'($urandom_range(1)),
					tbc_pkg::blk_t'($urandom_range(255)));
			end
		end

		settle();
		if (errors == 0 && results_due == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
